// ----- hdl/bgu_pkg.sv -----
// Package for the binned grid update core.
// Holds the default grid size, operation codes, register indexes and sequencer states.
// No dependencies.
package bgu_pkg;

	localparam int MAX_COLS_DEF = 64;
	localparam int MAX_ROWS_DEF = 64;

	localparam int DATA_W    = 32;
	localparam int BINS_W    = 7;
	localparam int CFG_IDX_W = 3;
	localparam int OUT_BIN_W = 6;

	typedef enum logic [1:0] {
		KIND_SET  = 2'd0,
		KIND_ADD  = 2'd1,
		KIND_MAX  = 2'd2,
		KIND_READ = 2'd3
	} kind_t;

	localparam logic [CFG_IDX_W-1:0] CFG_X_ORIGIN = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_Y_ORIGIN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_X_SCALE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_Y_SCALE  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_X_BINS   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_Y_BINS   = 3'd5;

	localparam logic [DATA_W-1:0] SCALE_RST = 32'h0001_0000;
	localparam logic [BINS_W-1:0] BINS_RST  = 7'd64;

	localparam logic [DATA_W-1:0] SAT_POS = 32'h7FFF_FFFF;
	localparam logic [DATA_W-1:0] SAT_NEG = 32'h8000_0000;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SUB,
		ST_MUL,
		ST_CLAMP,
		ST_READ,
		ST_WRITE
	} state_t;

endpackage

// ----- hdl/bgu_bin_map.sv -----
// Coordinate to bin mapper: subtract origin, multiply by scale, clamp.
// Three register stages, one coordinate. Depends on bgu_pkg.
module bgu_bin_map #(
	parameter int CAP   = bgu_pkg::MAX_COLS_DEF,
	parameter int BIN_W = $clog2(CAP)
) (
	input  logic                                clk,
	input  logic signed [bgu_pkg::DATA_W-1:0]   coord,
	input  logic signed [bgu_pkg::DATA_W-1:0]   origin,
	input  logic        [bgu_pkg::DATA_W-1:0]   scale,
	input  logic        [bgu_pkg::BINS_W-1:0]   used,
	output logic        [BIN_W-1:0]             bin
);
	import bgu_pkg::*;

	logic signed [DATA_W:0]   diff;
	logic                     neg_s1;
	logic        [DATA_W-1:0] mag_s1;
	logic                     neg_s2;
	logic        [2*DATA_W-1:0] prod;
	logic        [DATA_W-1:0] hi_s2;
	logic        [DATA_W-1:0] used_ext;
	logic        [DATA_W-1:0] lim;
	logic        [DATA_W-1:0] bin_full;
	logic        [BIN_W-1:0]  bin_s3;

	assign diff = {coord[DATA_W-1], coord} - {origin[DATA_W-1], origin};
	assign prod = {{DATA_W{1'b0}}, mag_s1} * {{DATA_W{1'b0}}, scale};

	always_ff @(posedge clk) begin
		neg_s1 <= diff[DATA_W];
		mag_s1 <= diff[DATA_W-1:0];
		neg_s2 <= neg_s1;
		hi_s2  <= prod[2*DATA_W-1:DATA_W];
		bin_s3 <= bin_full[BIN_W-1:0];
	end

	always_comb begin
		used_ext = DATA_W'(used);
		lim = (used_ext > DATA_W'(CAP)) ? DATA_W'(CAP) : used_ext;
		if (lim == '0) begin
			lim = DATA_W'(1);
		end
		if (neg_s2) begin
			bin_full = '0;
		end else if (hi_s2 >= lim) begin
			bin_full = lim - DATA_W'(1);
		end else begin
			bin_full = hi_s2;
		end
	end

	assign bin = bin_s3;

endmodule

// ----- hdl/bgu_cell_mem.sv -----
// Grid cell store: single-port-write, registered-read memory with a zero sweep after reset.
// Depends on bgu_pkg.
module bgu_cell_mem #(
	parameter int DEPTH  = bgu_pkg::MAX_COLS_DEF * bgu_pkg::MAX_ROWS_DEF,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          rd_en,
	input  logic [ADDR_W-1:0]             rd_addr,
	output logic [bgu_pkg::DATA_W-1:0]    rd_data,
	input  logic                          wr_en,
	input  logic [ADDR_W-1:0]             wr_addr,
	input  logic [bgu_pkg::DATA_W-1:0]    wr_data,
	output logic                          busy
);
	import bgu_pkg::*;

	logic [DATA_W-1:0] mem [DEPTH];
	logic [ADDR_W-1:0] clr_cnt_q;
	logic              clr_busy_q;
	logic [ADDR_W-1:0] w_addr;
	logic [DATA_W-1:0] w_data;
	logic              w_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q  <= '0;
			clr_busy_q <= 1'b1;
		end else if (clr_busy_q) begin
			clr_cnt_q <= clr_cnt_q + ADDR_W'(1);
			if (clr_cnt_q == ADDR_W'(DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	always_comb begin
		w_en   = clr_busy_q | wr_en;
		w_addr = clr_busy_q ? clr_cnt_q : wr_addr;
		w_data = clr_busy_q ? '0 : wr_data;
	end

	always_ff @(posedge clk) begin
		if (w_en) begin
			mem[w_addr] <= w_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

	assign busy = clr_busy_q;

endmodule

// ----- hdl/binned_grid_update_core.sv -----
// Top level of the binned grid update core: config registers, sequencer, cell update.
// Instantiates bgu_bin_map (x and y) and bgu_cell_mem. Depends on bgu_pkg.
//
//  channel  | direction | handshake           | contents
//  s_*      | in        | s_tvalid / s_tready | kind, x_coord, y_coord, sample_value
//  m_*      | out       | m_tvalid / m_tready | bin_col, bin_row, cell_value, saturated
//  cfg_*    | in        | cfg_wr_en           | register index, write data
//
// Each word passes through these steps in order: accept, subtract, 32x32 multiply, clamp,
// cell read, update. They follow the bin mapping register stages and the registered memory read.
// After reset a zero sweep runs over all MAX_COLS*MAX_ROWS cells, one a cycle; s_tready
// stays low meanwhile, and config writes are taken.
// A result waits in the output register; the update stage holds while it is not taken,
// and the next input word is accepted only once the update stage has gone back to idle.
module binned_grid_update_core #(
	parameter int MAX_COLS = bgu_pkg::MAX_COLS_DEF,
	parameter int MAX_ROWS = bgu_pkg::MAX_ROWS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [95:0]                       s_tdata,  // x_coord, y_coord, sample_value
	input  logic [1:0]                        s_tuser,  // kind
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [47:0]                       m_tdata,  // bin_col, bin_row, cell_value, zero pad
	output logic                              m_tuser,  // saturated
	input  logic                              cfg_wr_en,
	input  logic [bgu_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bgu_pkg::DATA_W-1:0]        cfg_data
);
	import bgu_pkg::*;

	localparam int DEPTH  = MAX_COLS * MAX_ROWS;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int COL_W  = $clog2(MAX_COLS);
	localparam int ROW_W  = $clog2(MAX_ROWS);

	logic signed [DATA_W-1:0] x_origin_q, y_origin_q;
	logic        [DATA_W-1:0] x_scale_q, y_scale_q;
	logic        [BINS_W-1:0] x_bins_q, y_bins_q;

	kind_t                    kind_q;
	logic signed [DATA_W-1:0] x_q, y_q, val_q;

	state_t state_q, state_nxt;

	logic [COL_W-1:0]  col;
	logic [ROW_W-1:0]  row;
	logic [ADDR_W-1:0] addr;
	logic [DATA_W-1:0] rd_data;
	logic              mem_busy;
	logic              rd_en;
	logic              wr_en;
	logic              in_fire;
	logic              upd_go;

	logic [DATA_W:0]   sum;
	logic [DATA_W-1:0] new_val;
	logic              new_sat;

	logic              out_valid_q;
	logic [DATA_W-1:0] out_val_q;
	logic              out_sat_q;
	logic [OUT_BIN_W-1:0] out_col_q, out_row_q;
	logic [DATA_W-1:0] col_ext, row_ext;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_origin_q <= '0;
			y_origin_q <= '0;
			x_scale_q  <= SCALE_RST;
			y_scale_q  <= SCALE_RST;
			x_bins_q   <= BINS_RST;
			y_bins_q   <= BINS_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_X_ORIGIN: x_origin_q <= cfg_data;
				CFG_Y_ORIGIN: y_origin_q <= cfg_data;
				CFG_X_SCALE:  x_scale_q  <= cfg_data;
				CFG_Y_SCALE:  y_scale_q  <= cfg_data;
				CFG_X_BINS:   x_bins_q   <= cfg_data[BINS_W-1:0];
				CFG_Y_BINS:   y_bins_q   <= cfg_data[BINS_W-1:0];
				default: ;
			endcase
		end
	end

	assign in_fire = s_tvalid & s_tready;
	assign upd_go  = (state_q == ST_WRITE) && (!out_valid_q || m_tready);

	always_ff @(posedge clk) begin
		if (in_fire) begin
			kind_q <= kind_t'(s_tuser);
			x_q    <= s_tdata[31:0];
			y_q    <= s_tdata[63:32];
			val_q  <= s_tdata[95:64];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_fire) state_nxt = ST_SUB;
			ST_SUB:   state_nxt = ST_MUL;
			ST_MUL:   state_nxt = ST_CLAMP;
			ST_CLAMP: state_nxt = ST_READ;
			ST_READ:  state_nxt = ST_WRITE;
			ST_WRITE: if (upd_go) state_nxt = ST_IDLE;
			default:  state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		rd_en    = 1'b0;
		wr_en    = 1'b0;
		unique case (state_q)
			ST_IDLE:  s_tready = ~mem_busy;
			ST_READ:  rd_en = 1'b1;
			ST_WRITE: wr_en = upd_go;
			default: ;
		endcase
	end

	bgu_bin_map #(.CAP(MAX_COLS), .BIN_W(COL_W)) u_x_map (
		.clk    (clk),
		.coord  (x_q),
		.origin (x_origin_q),
		.scale  (x_scale_q),
		.used   (x_bins_q),
		.bin    (col)
	);

	bgu_bin_map #(.CAP(MAX_ROWS), .BIN_W(ROW_W)) u_y_map (
		.clk    (clk),
		.coord  (y_q),
		.origin (y_origin_q),
		.scale  (y_scale_q),
		.used   (y_bins_q),
		.bin    (row)
	);

	assign addr = ADDR_W'(col) * ADDR_W'(MAX_ROWS) + ADDR_W'(row);

	bgu_cell_mem #(.DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (addr),
		.wr_data (new_val),
		.busy    (mem_busy)
	);

	// cell update
	always_comb begin
		sum     = {rd_data[DATA_W-1], rd_data} + {val_q[DATA_W-1], val_q};
		new_val = rd_data;
		new_sat = 1'b0;
		case (kind_q)
			KIND_SET: new_val = val_q;
			KIND_ADD: begin
				if (sum[DATA_W] != sum[DATA_W-1]) begin
					new_val = sum[DATA_W] ? SAT_NEG : SAT_POS;
					new_sat = 1'b1;
				end else begin
					new_val = sum[DATA_W-1:0];
				end
			end
			KIND_MAX: if ($signed(rd_data) < val_q) new_val = val_q;
			default: new_val = rd_data;
		endcase
	end

	assign col_ext = DATA_W'(col);
	assign row_ext = DATA_W'(row);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (upd_go) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (upd_go) begin
			out_col_q <= col_ext[OUT_BIN_W-1:0];
			out_row_q <= row_ext[OUT_BIN_W-1:0];
			out_val_q <= new_val;
			out_sat_q <= new_sat;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0, out_val_q, out_row_q, out_col_q};
	assign m_tuser  = out_sat_q;

endmodule
